// File: design/wbps_pkg.sv
// shared types and constants for the wildcard byte pattern scanner
// depends on nothing; imported by every other file of the block

package wbps_pkg;

   // number of pattern byte slots held in the configuration registers
   localparam int PATTERN_SLOTS        = 16;
   localparam int MAX_PATTERN_DEFAULT  = 16;
   localparam int ADDRESS_BITS_DEFAULT = 32;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int LENGTH_BITS    = 5;
   localparam int WORD_BITS      = 32;

   // result queue depth; the input is held off unless two entries are free
   localparam int RSP_FIFO_DEPTH = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_HIGH = 3'd1,
      REG_CARE_MASK    = 3'd2,
      REG_PATTERN_LEN  = 3'd3,
      REG_BASE_ADDRESS = 3'd4
   } csr_index_type;

   localparam logic KIND_REPORT  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef logic [PATTERN_SLOTS-1:0][7:0] pattern_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic                 result_kind;
      logic [WORD_BITS-1:0] match_address;
      logic [WORD_BITS-1:0] match_count;
      logic [WORD_BITS-1:0] unique_address;
      logic                 end_of_run;
   } rsp_payload_type;

   // what the scan logic hands to the result queue in one cycle
   typedef struct packed {
      logic push_first;
      logic push_second;
   } push_ctl_type;

endpackage

// File: design/wbps_chan_if.sv
// valid/ready channel carrying one payload beat
// depends on wbps_pkg for the payload types used by its instances

interface wbps_chan_if
   import wbps_pkg::*;
#(
   parameter type payload_type = req_payload_type
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: design/wbps_cell.sv
// one cell of the byte window: compares the byte of one age and holds it for the next cell
// depends on wbps_pkg for the pattern type

module wbps_cell
   import wbps_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  logic                   clear_en,
   input  logic [7:0]             byte_in,
   input  pattern_type            pattern,
   input  logic [PATTERN_SLOTS-1:0] care_mask,
   input  logic [LENGTH_BITS-1:0] pattern_length,
   output logic [7:0]             byte_out,
   output logic                   hit
);

   logic [7:0]             window_byte_ff;
   logic [7:0]             window_byte_in;
   logic                   in_use;
   logic [LENGTH_BITS-1:0] slot_wide;
   logic [3:0]             slot;

   // this cell sees the byte of age CELL_INDEX, matched against slot len-1-age
   assign in_use    = LENGTH_BITS'(CELL_INDEX) < pattern_length;
   assign slot_wide = pattern_length - LENGTH_BITS'(1) - LENGTH_BITS'(CELL_INDEX);
   assign slot      = slot_wide[3:0];

   assign hit = !in_use || !care_mask[slot] || (byte_in == pattern[slot]);

   always_comb begin
      window_byte_in = window_byte_ff;
      if (clear_en) begin
         window_byte_in = '0;
      end else if (shift_en) begin
         window_byte_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_byte_ff <= '0;
      end else begin
         window_byte_ff <= window_byte_in;
      end
   end

   assign byte_out = window_byte_ff;

endmodule

// File: design/wbps_rsp_fifo.sv
// small result queue taking up to two beats a cycle, giving one
// depends on wbps_pkg and wbps_chan_if

module wbps_rsp_fifo
   import wbps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  push_ctl_type     push_ctl,
   input  rsp_payload_type  first_beat,
   input  rsp_payload_type  second_beat,
   output logic             room_for_two,
   wbps_chan_if.source      rsp_chan
);

   localparam int PTR_BITS   = $clog2(RSP_FIFO_DEPTH);
   localparam int COUNT_BITS = $clog2(RSP_FIFO_DEPTH + 1);

   rsp_payload_type [RSP_FIFO_DEPTH-1:0] entry_ff;
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0]   wr_next;
   logic                  pop;
   logic [1:0]            n_push;

   assign pop     = rsp_chan.valid && rsp_chan.ready;
   assign n_push  = {1'b0, push_ctl.push_first} + {1'b0, push_ctl.push_second};
   assign wr_next = wr_ptr_ff + PTR_BITS'(1);

   assign rsp_chan.valid = count_ff != '0;
   assign rsp_chan.data  = entry_ff[rd_ptr_ff];
   assign room_for_two   = count_ff <= COUNT_BITS'(RSP_FIFO_DEPTH - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + COUNT_BITS'(n_push) - COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (push_ctl.push_first) begin
         entry_ff[wr_ptr_ff] <= first_beat;
      end
      if (push_ctl.push_second) begin
         entry_ff[wr_next] <= second_beat;
      end
   end

endmodule

// File: design/wildcard_byte_pattern_scanner_top.sv
// wildcard byte pattern scanner, top level
// a result beat enters the result queue as its byte is accepted, and is offered from there
// throughput: one byte per cycle; the byte window shifts and all cells compare
//   in that cycle; the input is held off while the result queue has fewer
//   than two free entries (a matching last byte gives two beats)
// reset: synchronous, clears configuration, window, run state and queue

module wildcard_byte_pattern_scanner_top
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN  = MAX_PATTERN_DEFAULT,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   wbps_chan_if.sink                 req_chan,
   wbps_chan_if.source               rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int FILL_BITS = $clog2(MAX_PATTERN + 1);
   localparam logic [WORD_BITS-1:0] ADDR_MASK =
      WORD_BITS'((64'd1 << ADDRESS_BITS) - 64'd1);

   // configuration registers
   logic [63:0]              pattern_low_ff;
   logic [63:0]              pattern_high_ff;
   logic [PATTERN_SLOTS-1:0] care_mask_ff;
   logic [LENGTH_BITS-1:0]   pattern_length_ff;
   logic [WORD_BITS-1:0]     base_address_ff;
   pattern_type              pattern;

   // run state
   logic [WORD_BITS-1:0] position_ff, position_in;
   logic [WORD_BITS-1:0] found_ff, found_in;
   logic [WORD_BITS-1:0] first_off_ff, first_off_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;

   logic                 accept;
   logic                 last;
   logic                 room_for_two;
   logic [7:0]           chain [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0] cell_hit;
   logic                 length_ok;
   logic                 match;
   logic [WORD_BITS-1:0] start_off;
   logic [WORD_BITS-1:0] first_addr;
   push_ctl_type         push_ctl;
   rsp_payload_type      report_beat, summary_beat;
   rsp_payload_type      first_beat, second_beat;

   assign pattern  = {pattern_high_ff, pattern_low_ff};
   assign accept   = req_chan.valid && req_chan.ready;
   assign last     = req_chan.data.last_byte;
   assign req_chan.ready = room_for_two;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '0;
         pattern_length_ff <= '0;
         base_address_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_PATTERN_LOW:  pattern_low_ff    <= csr_write_data;
            REG_PATTERN_HIGH: pattern_high_ff   <= csr_write_data;
            REG_CARE_MASK:    care_mask_ff      <= csr_write_data[PATTERN_SLOTS-1:0];
            REG_PATTERN_LEN:  pattern_length_ff <= csr_write_data[LENGTH_BITS-1:0];
            REG_BASE_ADDRESS: base_address_ff   <= csr_write_data[WORD_BITS-1:0];
            default: ;   // unknown index is ignored
         endcase
      end
   end

   // window as a chain of cells, newest byte enters cell 0; a clear care bit
   // acts as the "??" wildcard
   assign chain[0] = req_chan.data.data_byte;

   for (genvar a = 0; a < MAX_PATTERN; a++) begin : g_cell
      wbps_cell #(
         .CELL_INDEX (a)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .shift_en       (accept),
         .clear_en       (accept && last),
         .byte_in        (chain[a]),
         .pattern        (pattern),
         .care_mask      (care_mask_ff),
         .pattern_length (pattern_length_ff),
         .byte_out       (chain[a+1]),
         .hit            (cell_hit[a])
      );
   end

   // window fill counts the valid bytes, saturating at the window depth
   always_comb begin
      fill_in = (fill_ff < FILL_BITS'(MAX_PATTERN)) ? fill_ff + FILL_BITS'(1) : fill_ff;
   end

   assign length_ok = (pattern_length_ff != '0)
                   && ((LENGTH_BITS+1)'(pattern_length_ff) <= (LENGTH_BITS+1)'(MAX_PATTERN))
                   && ((LENGTH_BITS+1)'(fill_in) >= (LENGTH_BITS+1)'(pattern_length_ff));
   assign match     = length_ok && (&cell_hit);

   // start offset of a match ending at this byte
   assign start_off = position_ff - (WORD_BITS'(pattern_length_ff) - WORD_BITS'(1));

   always_comb begin
      found_in     = found_ff;
      first_off_in = first_off_ff;
      if (match) begin
         if (found_ff == '0) begin
            first_off_in = start_off;
         end
         if (found_ff != '1) begin
            found_in = found_ff + WORD_BITS'(1);
         end
      end
      position_in = position_ff + WORD_BITS'(1);
   end

   assign first_addr = (found_in != '0) ? ((base_address_ff + first_off_in) & ADDR_MASK) : '0;

   always_comb begin
      report_beat.result_kind    = KIND_REPORT;
      report_beat.match_address  = (base_address_ff + start_off) & ADDR_MASK;
      report_beat.match_count    = found_in;
      report_beat.unique_address = '0;
      report_beat.end_of_run     = !last;   // flagged on reports that are not last

      summary_beat.result_kind    = KIND_SUMMARY;
      summary_beat.match_address  = first_addr;
      summary_beat.match_count    = found_in;
      summary_beat.unique_address = (found_in == WORD_BITS'(1)) ? first_addr : '0;
      summary_beat.end_of_run     = 1'b1;
   end

   // a report comes before the summary when both follow from one byte
   always_comb begin
      push_ctl.push_first  = accept && (match || last);
      push_ctl.push_second = accept && match && last;
      first_beat           = match ? report_beat : summary_beat;
      second_beat          = summary_beat;
   end

   // run state, cleared after the last byte of a run
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         found_ff     <= '0;
         first_off_ff <= '0;
         fill_ff      <= '0;
      end else if (accept) begin
         if (last) begin
            position_ff  <= '0;
            found_ff     <= '0;
            first_off_ff <= '0;
            fill_ff      <= '0;
         end else begin
            position_ff  <= position_in;
            found_ff     <= found_in;
            first_off_ff <= first_off_in;
            fill_ff      <= fill_in;
         end
      end
   end

   wbps_rsp_fifo u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_ctl     (push_ctl),
      .first_beat   (first_beat),
      .second_beat  (second_beat),
      .room_for_two (room_for_two),
      .rsp_chan     (rsp_chan)
   );

endmodule

// File: design/wbps_checker.sv
// port-level checks on the result channel of the scanner
// depends on wbps_pkg; bound to wildcard_byte_pattern_scanner_top

module wbps_checker
   import wbps_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_summary_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_SUMMARY |-> rsp_data.end_of_run)
      else $error("summary beat without end of run");

   a_report_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_REPORT
         |-> rsp_data.unique_address == '0 && rsp_data.match_count != '0)
      else $error("report beat with bad count or unique address");

   a_unique_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.unique_address != '0
         |-> rsp_data.result_kind == KIND_SUMMARY
             && rsp_data.match_count == WORD_BITS'(1)
             && rsp_data.unique_address == rsp_data.match_address)
      else $error("unique address given without a single match");

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

// File: dv/wbps_scan_checker.sv
// result checker for the wildcard byte pattern scanner: predicts every result beat
// from the accepted input beats and the register writes, and compares
// depends on wbps_pkg for payload types, register indexes and sizes

module wbps_scan_checker
   import wbps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_payload_type           req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_payload_type           rsp_data,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output int                        mismatch_count,
   output int                        pending_results
);

   // register copies; pattern_bits holds the high register above the low one
   logic [PATTERN_SLOTS*8-1:0] pattern_bits;
   logic [PATTERN_SLOTS-1:0]   care_bits;
   logic [LENGTH_BITS-1:0]     pattern_len;
   logic [WORD_BITS-1:0]       base_addr;

   // run state, window[0] is the newest byte
   logic [7:0]           window [PATTERN_SLOTS];
   int                   window_fill;
   logic [WORD_BITS-1:0] run_offset;
   logic [WORD_BITS-1:0] matches_seen;
   logic [WORD_BITS-1:0] first_offset;

   rsp_payload_type expected_beats [$];

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic clear_run();
      for (int i = 0; i < PATTERN_SLOTS; i++) window[i] = 8'h00;
      window_fill  = 0;
      run_offset   = '0;
      matches_seen = '0;
      first_offset = '0;
   endtask

   task automatic scan_byte(input logic [7:0] data_byte, input logic last_byte);
      logic [WORD_BITS-1:0] offset;
      logic [WORD_BITS-1:0] start;
      logic [WORD_BITS-1:0] first_addr;
      int                   len;
      bit                   hit;
      rsp_payload_type      beat;
      for (int i = PATTERN_SLOTS - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = data_byte;
      if (window_fill < PATTERN_SLOTS) window_fill++;
      offset     = run_offset;
      run_offset = run_offset + 1'b1;
      len        = int'(pattern_len);
      hit = (len != 0) && (len <= PATTERN_SLOTS) && (window_fill >= len);
      if (hit) begin
         for (int j = 0; j < len; j++)
            if (care_bits[j] && window[len-1-j] != pattern_bits[8*j +: 8]) hit = 0;
      end
      if (hit) begin
         start = offset - WORD_BITS'(len - 1);
         if (matches_seen == '0) first_offset = start;
         if (matches_seen != '1) matches_seen = matches_seen + 1'b1;
         beat.result_kind    = KIND_REPORT;
         beat.match_address  = base_addr + start;
         beat.match_count    = matches_seen;
         beat.unique_address = '0;
         beat.end_of_run     = !last_byte;
         expected_beats.insert(expected_beats.size(), beat);
      end
      if (last_byte) begin
         // summary takes the base address as it stands now
         first_addr = (matches_seen != '0) ? base_addr + first_offset : '0;
         beat.result_kind    = KIND_SUMMARY;
         beat.match_address  = first_addr;
         beat.match_count    = matches_seen;
         beat.unique_address = (matches_seen == 1) ? first_addr : '0;
         beat.end_of_run     = 1'b1;
         expected_beats.insert(expected_beats.size(), beat);
         clear_run();
      end
   endtask

   task automatic check_beat(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_beats.size() == 0) begin
         report_mismatch($sformatf("result beat with nothing expected: kind %b address %h",
                                   got.result_kind, got.match_address));
      end else begin
         want = expected_beats.pop_front();
         if (got.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind got %b want %b",
                                      got.result_kind, want.result_kind));
         if (got.match_address !== want.match_address)
            report_mismatch($sformatf("match_address got %h want %h",
                                      got.match_address, want.match_address));
         if (got.match_count !== want.match_count)
            report_mismatch($sformatf("match_count got %h want %h",
                                      got.match_count, want.match_count));
         if (got.unique_address !== want.unique_address)
            report_mismatch($sformatf("unique_address got %h want %h",
                                      got.unique_address, want.unique_address));
         if (got.end_of_run !== want.end_of_run)
            report_mismatch($sformatf("end_of_run got %b want %b",
                                      got.end_of_run, want.end_of_run));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern_bits = '0;
         care_bits    = '0;
         pattern_len  = '0;
         base_addr    = '0;
         clear_run();
         expected_beats.delete();
      end else begin
         if (req_valid && req_ready) scan_byte(req_data.data_byte, req_data.last_byte);
         if (rsp_valid && rsp_ready) check_beat(rsp_data);
         if (csr_write_enable) begin
            case (csr_index)
               REG_PATTERN_LOW:  pattern_bits[63:0]   = csr_write_data;
               REG_PATTERN_HIGH: pattern_bits[127:64] = csr_write_data;
               REG_CARE_MASK:    care_bits            = csr_write_data[PATTERN_SLOTS-1:0];
               REG_PATTERN_LEN:  pattern_len          = csr_write_data[LENGTH_BITS-1:0];
               REG_BASE_ADDRESS: base_addr            = csr_write_data[WORD_BITS-1:0];
               default: ;
            endcase
         end
      end
      pending_results = expected_beats.size();
   end

endmodule

// File: dv/tb_wildcard_byte_pattern_scanner_top.sv
// testbench top for the wildcard byte pattern scanner: clock, reset, byte stimulus,
// register writes, result-side back-pressure and the final verdict
// depends on wbps_pkg, wbps_chan_if, the scanner top level and wbps_scan_checker

module tb_wildcard_byte_pattern_scanner_top;
   import wbps_pkg::*;

   // indexes that decode to no register, written to show they are ignored
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LOW  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HIGH = 3'd7;

   localparam int RANDOM_PHASES   = 12;
   localparam int BYTES_PER_PHASE = 88;
   localparam int LONG_HOLD       = 120;

   logic clock = 1'b0;
   logic reset;

   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   wbps_chan_if #(.payload_type(req_payload_type)) req_chan ();
   wbps_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   int mismatch_count;
   int pending_results;

   // idle rates in percent, and a request counter for a long receiver hold
   int sender_idle_pct;
   int rsp_idle_pct;
   int holds_asked;

   // stimulus-side copy of the current setup, used to build well-formed occurrences
   logic [PATTERN_SLOTS*8-1:0] stim_pattern;
   logic [PATTERN_SLOTS-1:0]   stim_care;
   logic [LENGTH_BITS-1:0]     stim_len;

   logic [7:0] directed_bytes [$];

   always #10 clock = ~clock;

   wildcard_byte_pattern_scanner_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   wbps_scan_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_data         (req_chan.data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_data         (rsp_chan.data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_results  (pending_results)
   );

   // offer one beat, starting at a falling edge; returns at the falling edge after
   // acceptance with valid still high, so back-to-back beats never drop valid
   // each cycle before the offer idles with the sender's idle rate
   task automatic send_beat(input logic [7:0] data_byte, input logic last_byte);
      req_payload_type beat;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      beat.data_byte = data_byte;
      beat.last_byte = last_byte;
      req_chan.valid <= 1'b1;
      req_chan.data  <= beat;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // stop offering and let every expected result drain, then a short settle so a
   // byte with no result is surely through the window before any write
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      repeat (3) @(negedge clock);
   endtask

   // enable is only lowered after the whole group, never between two writes
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
   endtask

   // narrow registers get random junk in their upper bits on purpose
   task automatic load_setup(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [63:0] care_w, input logic [63:0] len_w,
                             input logic [63:0] base_w);
      logic [CSR_INDEX_BITS-1:0] spare_idx;
      spare_idx = CSR_INDEX_BITS'($urandom_range(REG_SPARE_LOW, REG_SPARE_HIGH));
      write_reg(REG_PATTERN_LOW, lo);
      write_reg(REG_CARE_MASK, care_w);
      write_reg(spare_idx, {$urandom, $urandom});
      write_reg(REG_PATTERN_HIGH, hi);
      write_reg(REG_PATTERN_LEN, len_w);
      write_reg(REG_BASE_ADDRESS, base_w);
      csr_write_enable <= 1'b0;
      stim_pattern = {hi, lo};
      stim_care    = care_w[PATTERN_SLOTS-1:0];
      stim_len     = len_w[LENGTH_BITS-1:0];
   endtask

   // directed run from the byte list; close_run marks the final byte as last
   task automatic send_directed_run(input bit close_run);
      for (int i = 0; i < directed_bytes.size(); i++)
         send_beat(directed_bytes[i], close_run && i == directed_bytes.size() - 1);
      directed_bytes.delete();
   endtask

   // setup for one random phase; a few phases pin the extremes
   task automatic pick_setup(input int phase);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] care_w;
      logic [63:0] len_w;
      logic [63:0] base_w;
      int          r;
      lo     = {$urandom, $urandom};
      hi     = {$urandom, $urandom};
      care_w = {$urandom, $urandom};
      len_w  = {$urandom, $urandom};
      base_w = {$urandom, $urandom};
      r = $urandom_range(99);
      if (r < 70)      len_w[4:0] = 5'($urandom_range(1, 4));
      else if (r < 85) len_w[4:0] = 5'($urandom_range(5, PATTERN_SLOTS));
      else if (r < 93) len_w[4:0] = '0;
      else             len_w[4:0] = 5'($urandom_range(PATTERN_SLOTS + 1, 31));
      case (phase)
         0: begin
            // all-zero pattern, every byte compared, full length, base zero
            lo = '0; hi = '0; care_w[15:0] = '1; len_w[4:0] = 5'(PATTERN_SLOTS);
            base_w[31:0] = '0;
         end
         1: begin
            // all-ones everywhere, addresses wrap straight away
            lo = '1; hi = '1; care_w = '1; len_w[4:0] = 5'(PATTERN_SLOTS);
            base_w[31:0] = '1;
         end
         2: begin
            // single wildcard byte: every byte matches, used for the long hold
            care_w[15:0] = '0; len_w[4:0] = 5'd1;
         end
         7: len_w[4:0] = '1;  // longest length the register holds, no matches
         default: ;
      endcase
      load_setup(lo, hi, care_w, len_w, base_w);
   endtask

   // mostly whole occurrences of the pattern with random wildcard bytes, some cut
   // short, the rest loose bytes drawn from the pattern or fully random
   task automatic emit_sequence(inout int sent);
      int         len;
      int         cut;
      int         r;
      logic [7:0] data_byte;
      len = int'(stim_len);
      r   = $urandom_range(99);
      if (len >= 1 && len <= PATTERN_SLOTS && r < 70) begin
         cut = (r < 55) ? len : $urandom_range(1, len);
         for (int j = 0; j < cut; j++) begin
            data_byte = stim_care[j] ? stim_pattern[8*j +: 8] : 8'($urandom);
            send_beat(data_byte, j == cut - 1 && $urandom_range(11) == 0);
            sent++;
         end
      end else begin
         if (len >= 1 && len <= PATTERN_SLOTS && $urandom_range(3) == 0)
            data_byte = stim_pattern[8*$urandom_range(len - 1) +: 8];
         else
            data_byte = 8'($urandom);
         send_beat(data_byte, $urandom_range(19) == 0);
         sent++;
      end
   endtask

   // result side: random back-pressure, or a long hold when one is asked for
   initial begin : rsp_drive
      int hold_left;
      int holds_served;
      hold_left     = 0;
      holds_served  = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // run limit, far above the slowest correct run
   initial begin
      #10_000_000;
      $display("FAIL wildcard_byte_pattern_scanner_top");
      $finish;
   end

   initial begin : stimulus
      int sent;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.data    = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      sender_idle_pct  = 32;
      rsp_idle_pct     = 50;
      holds_asked      = 0;
      stim_pattern     = '0;
      stim_care        = '0;
      stim_len         = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty pattern straight out of reset: only an all-zero summary
      directed_bytes = '{8'hFF, 8'h00, 8'h80};
      send_directed_run(1'b1);
      wait_idle();

      // AA ?? BB, base just below the wrap: two matches, the second on the last
      // byte so a report and a summary come from the same beat
      load_setup(64'h0000_0000_00BB_5AAA, '1, 64'hFFFF_FFFF_FFFF_0005,
                 64'hFFFF_FFFF_FFFF_FFE3, 64'hDEAD_BEEF_FFFF_FFFE);
      directed_bytes = '{8'hAA, 8'h01, 8'hBB, 8'hAA, 8'hBB, 8'hBB};
      send_directed_run(1'b1);
      wait_idle();

      // exactly one match, so the summary carries a unique address
      directed_bytes = '{8'hAA, 8'h00, 8'hBB, 8'h00};
      send_directed_run(1'b1);
      wait_idle();

      // length seventeen through junk upper bits: longer than the window, no match
      load_setup(64'hFFFF_FFFF_FFFF_FFF1, '1, '1, 64'hFFFF_FFFF_FFFF_FFF1, '0);
      directed_bytes = '{8'hFF, 8'hFF};
      send_directed_run(1'b1);
      wait_idle();

      // one compared byte matching on the last byte of the run
      load_setup(64'h0000_0000_0000_00FF, '0, 64'h1, 64'h1, '0);
      directed_bytes = '{8'h00, 8'hFF};
      send_directed_run(1'b1);
      wait_idle();

      // run shorter than the pattern gives only a summary
      load_setup('0, '0, '0, 64'h3, '0);
      directed_bytes = '{8'h12, 8'h34};
      send_directed_run(1'b1);
      wait_idle();

      // base moved in the middle of a run: reports use the base of their beat,
      // the summary the base at its end
      load_setup('0, '0, '0, 64'h2, 64'h100);
      directed_bytes = '{8'h01, 8'h02};
      send_directed_run(1'b0);
      wait_idle();
      load_setup('0, '0, '0, 64'h2, 64'h200);
      directed_bytes = '{8'h03};
      send_directed_run(1'b1);

      // random phases: receiver idles more first, then the sender, then neither;
      // each setup change waits for the results to drain
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 4) begin
            sender_idle_pct = 32;
            rsp_idle_pct    = 50;
         end else if (phase < 8) begin
            sender_idle_pct = 50;
            rsp_idle_pct    = 32;
         end else begin
            sender_idle_pct = 0;
            rsp_idle_pct    = 0;
         end
         wait_idle();
         pick_setup(phase);
         // every byte matches here, so holding the receiver fills the result
         // queue and the input backs up while the sender keeps offering
         if (phase == 2) holds_asked++;
         sent = 0;
         while (sent < BYTES_PER_PHASE) emit_sequence(sent);
      end

      wait_idle();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("PASS wildcard_byte_pattern_scanner_top");
      else
         $display("FAIL wildcard_byte_pattern_scanner_top");
      $finish;
   end

endmodule
